### design/assert_macros.svh
// Assertion shorthands shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/dcq_pkg.sv
package dcq_pkg;

    // Opcodes
    localparam logic [1:0] OP_PUSH_ONE = 2'd0;
    localparam logic [1:0] OP_PUSH_TWO = 2'd1;
    localparam logic [1:0] OP_POP_ONE  = 2'd2;
    localparam logic [1:0] OP_POP_TWO  = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam int          VAL_W       = 32;
    localparam logic [31:0] EMPTY_VALUE = 32'hFFFF_FFFB;  // -5

    // Config register
    localparam int            CFG_W          = 5;
    localparam logic [4:0]    HALF_CAP_RESET = 5'd16;
    localparam int            PADDR_W        = 3;
    localparam logic [0:0]    REG_HALF_CAP   = 1'b0;

    typedef struct packed {
        logic accept;    // item taken this cycle
        logic load_out;  // move finished result into output register
    } t_dp_cmd;

endpackage

### design/dcq_if.sv
interface dcq_in_if;
    import dcq_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [1:0]              opcode;
    logic signed [VAL_W-1:0] push_value;

    modport source (output valid, output opcode, output push_value, input ready);
    modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface dcq_out_if;
    import dcq_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] pop_value;
    logic [1:0]              status;

    modport source (output valid, output pop_value, output status, input ready);
    modport sink   (input valid, input pop_value, input status, output ready);
endinterface

### design/dcq_ram.sv
module dcq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                      i_wdata,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### design/dcq_ctrl.sv
module dcq_ctrl
    import dcq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_ready,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);
`include "assert_macros.svh"

    typedef enum logic {
        S_IDLE,
        S_RES    // result of last item sits in the datapath
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd.load_out = (r_state == S_RES) && w_out_free;
        o_in_ready     = (r_state == S_IDLE) || o_cmd.load_out;
        o_cmd.accept   = i_in_valid && o_in_ready;

        n_state = r_state;
        if (o_cmd.accept) begin
            n_state = S_RES;
        end else if (o_cmd.load_out) begin
            n_state = S_IDLE;
        end

        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `ASSERT_IMPLIES(a_acc_drains, i_clk, i_rst_n, o_cmd.accept && (r_state == S_RES),
        o_cmd.load_out, "item taken over a result that was not moved out")
    `ASSERT_NEXT(a_load_valid, i_clk, i_rst_n, o_cmd.load_out,
        r_out_valid, "loaded result not presented")
    `ASSERT_IMPLIES(a_idle_no_load, i_clk, i_rst_n, r_state == S_IDLE,
        !o_cmd.load_out, "output loaded with no result pending")
endmodule

### design/dcq_dp.sv
module dcq_dp
    import dcq_pkg::*;
#(
    parameter int HALF_DEPTH = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    input  logic [1:0]       i_opcode,
    input  logic [VAL_W-1:0] i_push_value,
    input  logic [CFG_W-1:0] i_half_cap,
    output logic [VAL_W-1:0] o_pop_value,
    output logic [1:0]       o_status
);
`include "assert_macros.svh"

    localparam int PTR_W  = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
    localparam int CAP_A  = $clog2(HALF_DEPTH + 1);
    localparam int CAP_W  = (CAP_A > CFG_W) ? CAP_A : CFG_W;
    localparam int ADDR_W = $clog2(2 * HALF_DEPTH);

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_EMPTY,
        RES_MEM
    } t_res_kind;

    logic [PTR_W-1:0] r_head [2];
    logic [PTR_W-1:0] r_tail [2];
    logic             r_ne   [2];
    logic [PTR_W-1:0] n_head [2];
    logic [PTR_W-1:0] n_tail [2];
    logic             n_ne   [2];

    t_res_kind        r_res_kind, n_res_kind;
    logic [1:0]       r_res_st, n_res_st;
    logic [VAL_W-1:0] r_out_val;
    logic [1:0]       r_out_st;

    logic [CAP_W-1:0]      w_hc, w_cap;
    logic                  w_sel, w_pop;
    logic [PTR_W-1:0]      w_tail_adv, w_head_adv, w_slot;
    logic                  w_we, w_re;
    logic [ADDR_W-1:0]     w_addr;
    logic [DATA_WIDTH-1:0] w_wdata, w_rdata;
    logic [VAL_W-1:0]      w_mem_val, w_res_val;

    // compare-and-wrap increment
    function automatic logic [PTR_W-1:0] f_adv(input logic [PTR_W-1:0] p,
                                               input logic [CAP_W-1:0] c);
        logic [CAP_W:0] s;
        s = (CAP_W + 1)'(p) + (CAP_W + 1)'(1);
        return (s >= (CAP_W + 1)'(c)) ? '0 : PTR_W'(s);
    endfunction

    // capacity in use, clamped to 1..HALF_DEPTH
    assign w_hc = CAP_W'(i_half_cap);
    always_comb begin
        priority if (w_hc == '0) begin
            w_cap = CAP_W'(1);
        end else if (w_hc > CAP_W'(HALF_DEPTH)) begin
            w_cap = CAP_W'(HALF_DEPTH);
        end else begin
            w_cap = w_hc;
        end
    end

    assign w_pop = (i_opcode == OP_POP_ONE) || (i_opcode == OP_POP_TWO);
    assign w_sel = (i_opcode == OP_PUSH_TWO) || (i_opcode == OP_POP_TWO);
    assign w_tail_adv = f_adv(r_tail[w_sel], w_cap);
    assign w_head_adv = f_adv(r_head[w_sel], w_cap);

    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_ne       = r_ne;
        n_res_kind = r_res_kind;
        n_res_st   = r_res_st;
        w_we       = 1'b0;
        w_re       = 1'b0;
        w_slot     = '0;
        if (i_cmd.accept) begin
            n_res_kind = RES_ZERO;
            n_res_st   = ST_OK;
            if (!w_pop) begin
                priority if (!r_ne[w_sel]) begin
                    n_head[w_sel] = '0;
                    n_tail[w_sel] = '0;
                    n_ne[w_sel]   = 1'b1;
                    w_we          = 1'b1;
                end else if (w_tail_adv == r_head[w_sel]) begin
                    n_res_st = ST_FULL;
                end else begin
                    n_tail[w_sel] = w_tail_adv;
                    w_slot        = w_tail_adv;
                    w_we          = 1'b1;
                end
            end else if (!r_ne[w_sel]) begin
                n_res_kind = RES_EMPTY;
                n_res_st   = ST_EMPTY;
            end else begin
                n_res_kind = RES_MEM;
                w_re       = 1'b1;
                w_slot     = r_head[w_sel];
                if (r_head[w_sel] == r_tail[w_sel]) begin
                    n_head[w_sel] = '0;
                    n_tail[w_sel] = '0;
                    n_ne[w_sel]   = 1'b0;
                end else begin
                    n_head[w_sel] = w_head_adv;
                end
            end
        end
    end

    assign w_addr = w_sel ? (ADDR_W'(HALF_DEPTH) + ADDR_W'(w_slot)) : ADDR_W'(w_slot);

    generate
        if (DATA_WIDTH >= VAL_W) begin : g_wide
            assign w_wdata   = DATA_WIDTH'(i_push_value);
            assign w_mem_val = w_rdata[VAL_W-1:0];
        end else begin : g_narrow
            assign w_wdata   = i_push_value[DATA_WIDTH-1:0];
            assign w_mem_val = {{(VAL_W - DATA_WIDTH){w_rdata[DATA_WIDTH-1]}}, w_rdata};
        end
    endgenerate

    dcq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (2 * HALF_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_re    (w_re),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    always_comb begin
        unique case (r_res_kind)
            RES_EMPTY: w_res_val = EMPTY_VALUE;
            RES_MEM:   w_res_val = w_mem_val;
            default:   w_res_val = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '{default: '0};
            r_tail <= '{default: '0};
            r_ne   <= '{default: 1'b0};
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_ne   <= n_ne;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_kind <= n_res_kind;
        r_res_st   <= n_res_st;
        if (i_cmd.load_out) begin
            r_out_val <= w_res_val;
            r_out_st  <= r_res_st;
        end
    end

    assign o_pop_value = r_out_val;
    assign o_status    = r_out_st;

    `ASSERT_IMPLIES(a_q1_empty_ptrs, i_clk, i_rst_n, !r_ne[0],
        (r_head[0] == '0) && (r_tail[0] == '0), "queue one empty with stray pointers")
    `ASSERT_IMPLIES(a_q2_empty_ptrs, i_clk, i_rst_n, !r_ne[1],
        (r_head[1] == '0) && (r_tail[1] == '0), "queue two empty with stray pointers")
endmodule

### design/dual_circular_queue.sv
// Two circular FIFO queues sharing one storage RAM: queue one in the
// lower half, queue two in the upper half, each using the first
// half_capacity slots of its half.
// Input channel i_item: one transfer is one operation (opcode + push_value):
//   push queue one, push queue two, pop queue one, pop queue two.
// Output channel o_result: exactly one transfer per operation, in order,
//   pop_value (dequeued value, -5 on empty pop, 0 on push) and status
//   (ok, full with the push dropped, empty).
// Results: a pop reads the registered RAM port at the accepting edge, and
//   the output register is loaded from the datapath once o_result is free.
// Throughput: one item per cycle while o_result is drained; the RAM port
//   and the pointer update are used at most once per item.
// Stall: the output register holds its result while ready is low; one
//   further item is taken and finished behind it, then i_item.ready drops.
// Reset (i_rst_n, synchronous): both queues empty, half_capacity = 16,
//   no result pending. Storage holds no reset value and needs no clearing.
// Config: APB register 0 (byte 0) is half_capacity; write it only while
//   no result is outstanding.
module dual_circular_queue
    import dcq_pkg::*;
#(
    parameter int HALF_DEPTH = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    dcq_in_if.sink             i_item,
    dcq_out_if.source          o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_dp_cmd          w_cmd;
    logic [CFG_W-1:0] r_half_cap;
    logic             w_cfg_wr, w_hit;

    // ---- config register ----
    assign pready   = 1'b1;
    assign w_hit    = (paddr[PADDR_W-1:2] == REG_HALF_CAP);
    assign w_cfg_wr = psel && penable && pwrite && pready && w_hit;
    assign prdata   = w_hit ? 32'(r_half_cap) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_cap <= HALF_CAP_RESET;
        end else if (w_cfg_wr) begin
            r_half_cap <= pwdata[CFG_W-1:0];
        end
    end

    // ---- transfer control ----
    dcq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_out_ready (o_result.ready),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .o_cmd       (w_cmd)
    );

    // ---- pointers, storage, result ----
    dcq_dp #(
        .HALF_DEPTH (HALF_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_opcode     (i_item.opcode),
        .i_push_value (i_item.push_value),
        .i_half_cap   (r_half_cap),
        .o_pop_value  (o_result.pop_value),
        .o_status     (o_result.status)
    );

endmodule
